>>> hw/rtl/sgmc_pkg.sv
`default_nettype none

package sgmc_pkg;

   localparam int TIME_BITS   = 16;
   localparam int CFG_BITS    = 16;
   localparam int CMP_BITS    = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int ACTION_BITS = 4;
   localparam int CAUSE_BITS  = 3;
   localparam int MODE_BITS   = 2;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;
   localparam int INDEX_BITS  = ADDR_BITS - 2;

   localparam logic [ACTION_BITS-1:0] ACT_TICK         = 4'd0;
   localparam logic [ACTION_BITS-1:0] ACT_BUTTON       = 4'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DETECT       = 4'd2;
   localparam logic [ACTION_BITS-1:0] ACT_BEAM         = 4'd3;
   localparam logic [ACTION_BITS-1:0] ACT_OPEN_LIMIT   = 4'd4;
   localparam logic [ACTION_BITS-1:0] ACT_CLOSE_LIMIT  = 4'd5;
   localparam logic [ACTION_BITS-1:0] ACT_OPEN_TORQUE  = 4'd6;
   localparam logic [ACTION_BITS-1:0] ACT_CLOSE_TORQUE = 4'd7;
   localparam logic [ACTION_BITS-1:0] ACT_OPEN         = 4'd8;
   localparam logic [ACTION_BITS-1:0] ACT_CLOSE        = 4'd9;
   localparam logic [ACTION_BITS-1:0] ACT_STOP         = 4'd10;

   localparam logic [CAUSE_BITS-1:0] CAUSE_NONE        = 3'd0;
   localparam logic [CAUSE_BITS-1:0] CAUSE_BEAM        = 3'd1;
   localparam logic [CAUSE_BITS-1:0] CAUSE_OPEN_LIMIT  = 3'd2;
   localparam logic [CAUSE_BITS-1:0] CAUSE_CLOSE_LIMIT = 3'd3;
   localparam logic [CAUSE_BITS-1:0] CAUSE_TIMEOUT     = 3'd4;
   localparam logic [CAUSE_BITS-1:0] CAUSE_TORQUE      = 3'd5;
   localparam logic [CAUSE_BITS-1:0] CAUSE_CONFLICT    = 3'd6;

   localparam logic [MODE_BITS-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ARMED  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_STORED = 2'd2;

   localparam logic [INDEX_BITS-1:0] REG_AUTOCLOSE_TICKS  = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_AUTOCLOSE_ENABLE = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_DETECT_ENABLE    = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_REVERSE_WIRING   = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_TORQUE_ENABLE    = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_MAX_TRAVEL       = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_TIMEOUT_ENABLE   = 3'd6;

   localparam logic [CFG_BITS-1:0] AUTOCLOSE_TICKS_RESET = 16'd120;
   localparam logic [CFG_BITS-1:0] MAX_TRAVEL_RESET      = 16'd100;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic                   beam_blocked;
      logic                   open_limit_hit;
      logic                   close_limit_hit;
      logic                   open_torque_high;
      logic                   close_torque_high;
      logic                   button_level;
   } req_type;

   typedef struct packed {
      logic                  motor_forward;
      logic                  motor_reverse;
      logic                  warning_light;
      logic                  heading_open;
      logic                  at_open_end;
      logic                  at_closed_end;
      logic [CAUSE_BITS-1:0] stop_cause;
   } rsp_type;

   typedef struct packed {
      logic                                moving;
      logic                                dir_open;
      logic                                opened;
      logic                                closed;
      logic                                button_latched;
      logic                                autoclose_blocked;
      logic [CFG_BITS-1:0]                 autoclose_left;
      logic [1:0][TIME_BITS-1:0]           run_start;
      logic [1:0][TIME_BITS-1:0]           learned_time;
      logic [1:0][MODE_BITS-1:0]           learned_mode;
   } gate_state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] tick;
      logic                 lvl_beam;
      logic                 lvl_olim;
      logic                 lvl_clim;
      logic [CFG_BITS-1:0]  max_travel;
      logic [CFG_BITS-1:0]  autoclose_ticks;
   } gate_ctx_type;

   localparam gate_state_type GATE_STATE_RESET = '{
      moving:            1'b0,
      dir_open:          1'b1,
      opened:            1'b0,
      closed:            1'b1,
      button_latched:    1'b0,
      autoclose_blocked: 1'b0,
      autoclose_left:    AUTOCLOSE_TICKS_RESET,
      run_start:         '0,
      learned_time:      '0,
      learned_mode:      {MODE_NONE, MODE_NONE}
   };

endpackage

`default_nettype wire

>>> hw/rtl/sgmc_req_if.sv
`default_nettype none

interface sgmc_req_if import sgmc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic                   beam_blocked;
   logic                   open_limit_hit;
   logic                   close_limit_hit;
   logic                   open_torque_high;
   logic                   close_torque_high;
   logic                   button_level;

   modport source (
      output valid, action, beam_blocked, open_limit_hit, close_limit_hit,
             open_torque_high, close_torque_high, button_level,
      input  ready
   );

   modport sink (
      input  valid, action, beam_blocked, open_limit_hit, close_limit_hit,
             open_torque_high, close_torque_high, button_level,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/sgmc_rsp_if.sv
`default_nettype none

interface sgmc_rsp_if import sgmc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  motor_forward;
   logic                  motor_reverse;
   logic                  warning_light;
   logic                  heading_open;
   logic                  at_open_end;
   logic                  at_closed_end;
   logic [CAUSE_BITS-1:0] stop_cause;

   modport source (
      output valid, motor_forward, motor_reverse, warning_light, heading_open,
             at_open_end, at_closed_end, stop_cause,
      input  ready
   );

   modport sink (
      input  valid, motor_forward, motor_reverse, warning_light, heading_open,
             at_open_end, at_closed_end, stop_cause,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/sliding_gate_motor_controller_core.sv
// Sliding gate drive sequencer.
// req: one request per event (tick, button, detect, sensor edge, torque,
//   open, close, stop) together with the current sensor levels.
// rsp: one result per request: motor drive, warning light, heading,
//   end-of-travel status and the safety stop taken by that request.
// csr: APB-style register port, register i at byte address 4*i, pready tied
//   high; writes land in the access cycle, reads return the register value.
// Path: a request taken sits in the input register, is decided by the gate
//   state logic and then lands in the result register once that register is
//   free or being emptied; rsp takes its result from there.
// Throughput: one request per cycle while rsp takes every result; the state
//   update is a single pass between the input register and the result register.
// Stall: when rsp is not taken, the result register holds, the input
//   register holds the next request and req.ready drops once both are full.
// Reset (synchronous): gate still, heading open, known closed, no learned
//   travel times, tick counter zero, registers at their default values.
`default_nettype none

module sliding_gate_motor_controller_core import sgmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sgmc_req_if.sink             req,
   sgmc_rsp_if.source           rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   logic [CFG_BITS-1:0] autoclose_ticks_ff;
   logic                autoclose_enable_ff;
   logic                detect_enable_ff;
   logic                reverse_wiring_ff;
   logic                torque_enable_ff;
   logic [CFG_BITS-1:0] max_travel_ff;
   logic                timeout_enable_ff;

   logic                  item_valid_ff, item_valid_in;
   req_type               item_ff;
   logic                  result_valid_ff, result_valid_in;
   rsp_type               result_ff, result_in;
   gate_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0]  tick_ff, tick_in;
   logic [CAUSE_BITS-1:0] cause;
   gate_ctx_type          ctx;
   logic                  advance;
   logic                  req_take;
   logic                  csr_write;
   logic [INDEX_BITS-1:0] reg_index;
   logic                  run_dir;
   logic [CMP_BITS-1:0]   run_limit;
   logic [CMP_BITS-1:0]   run_elapsed;

   function automatic logic f_at_end(gate_state_type s, gate_ctx_type c);
      return c.lvl_olim || s.opened || c.lvl_clim || s.closed;
   endfunction

   function automatic logic f_must(gate_state_type s, logic d, logic [CFG_BITS-1:0] m);
      logic [CMP_BITS+2:0] tx, mx, t5, m4;
      tx = (CMP_BITS+3)'(s.learned_time[d]);
      mx = (CMP_BITS+3)'(m);
      t5 = (tx << 2) + tx;
      m4 = mx << 2;
      return !((s.learned_mode[d] == MODE_STORED) && (t5 >= m4) && (tx <= mx));
   endfunction

   function automatic gate_state_type f_halt(gate_state_type s, gate_ctx_type c);
      gate_state_type r;
      logic           d;
      r = s;
      d = s.dir_open;
      if (f_must(s, d, c.max_travel)) begin
         if ((s.learned_mode[d] != MODE_NONE) && s.moving && f_at_end(s, c)) begin
            r.learned_time[d] = c.tick - s.run_start[d];
            r.learned_mode[d] = MODE_STORED;
         end else begin
            r.learned_mode[d] = MODE_NONE;
         end
      end
      if (s.moving) begin
         r.moving         = 1'b0;
         r.autoclose_left = c.autoclose_ticks;
      end
      return r;
   endfunction

   function automatic gate_state_type f_begin(gate_state_type s, gate_ctx_type c, logic d);
      gate_state_type r;
      r = s;
      r.moving = 1'b1;
      r.run_start[d] = c.tick;
      if (f_must(s, d, c.max_travel)) begin
         r.learned_mode[d] = f_at_end(s, c) ? MODE_ARMED : MODE_NONE;
      end
      return r;
   endfunction

   function automatic gate_state_type f_go_open(gate_state_type s, gate_ctx_type c);
      gate_state_type r;
      r = f_halt(s, c);
      r.dir_open = 1'b1;
      r.closed   = 1'b0;
      if (c.lvl_olim || r.opened) begin
         r.dir_open = 1'b0;
      end else begin
         r = f_begin(r, c, 1'b1);
      end
      return r;
   endfunction

   function automatic gate_state_type f_go_close(gate_state_type s, gate_ctx_type c);
      gate_state_type r;
      r = f_halt(s, c);
      r.dir_open = 1'b0;
      if (!c.lvl_beam) begin
         r.opened = 1'b0;
         if (c.lvl_clim || r.closed) begin
            r.dir_open = 1'b1;
         end else begin
            r = f_begin(r, c, 1'b0);
         end
      end
      return r;
   endfunction

   // handshake
   assign advance         = item_valid_ff && (!result_valid_ff || rsp.ready);
   assign req.ready       = !item_valid_ff || advance;
   assign req_take        = req.valid && req.ready;
   assign item_valid_in   = req_take || (item_valid_ff && !advance);
   assign result_valid_in = advance || (result_valid_ff && !rsp.ready);

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[ADDR_BITS-1:2];

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         REG_AUTOCLOSE_TICKS:  csr_prdata = DATA_BITS'(autoclose_ticks_ff);
         REG_AUTOCLOSE_ENABLE: csr_prdata = DATA_BITS'(autoclose_enable_ff);
         REG_DETECT_ENABLE:    csr_prdata = DATA_BITS'(detect_enable_ff);
         REG_REVERSE_WIRING:   csr_prdata = DATA_BITS'(reverse_wiring_ff);
         REG_TORQUE_ENABLE:    csr_prdata = DATA_BITS'(torque_enable_ff);
         REG_MAX_TRAVEL:       csr_prdata = DATA_BITS'(max_travel_ff);
         REG_TIMEOUT_ENABLE:   csr_prdata = DATA_BITS'(timeout_enable_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // gate state update for the request in the input register
   assign tick_in = (item_ff.action == ACT_TICK) ? tick_ff + 1'b1 : tick_ff;

   always_comb begin
      ctx.tick            = tick_in;
      ctx.lvl_beam        = item_ff.beam_blocked;
      ctx.lvl_olim        = item_ff.open_limit_hit;
      ctx.lvl_clim        = item_ff.close_limit_hit;
      ctx.max_travel      = max_travel_ff;
      ctx.autoclose_ticks = autoclose_ticks_ff;
   end

   always_comb begin
      state_in    = state_ff;
      cause       = CAUSE_NONE;
      run_dir     = 1'b0;
      run_limit   = '0;
      run_elapsed = '0;
      case (item_ff.action)
         ACT_TICK: begin
            if (!(ctx.lvl_clim || state_in.closed) && autoclose_enable_ff &&
                !state_in.autoclose_blocked && !state_in.moving) begin
               if (state_in.autoclose_left == '0) begin
                  state_in = f_go_close(state_in, ctx);
               end else begin
                  state_in.autoclose_left = state_in.autoclose_left - 1'b1;
               end
            end
            if (state_in.button_latched && !item_ff.button_level) begin
               state_in.button_latched = 1'b0;
            end
         end
         ACT_BUTTON: begin
            if (!state_in.button_latched) begin
               state_in.button_latched = 1'b1;
               if (state_in.moving) begin
                  state_in = f_halt(state_in, ctx);
                  state_in.dir_open = !state_in.dir_open;
               end else begin
                  if (ctx.lvl_beam) begin
                     state_in.dir_open = 1'b1;
                  end
                  if (state_in.dir_open) begin
                     state_in = f_go_open(state_in, ctx);
                  end else begin
                     state_in = f_go_close(state_in, ctx);
                  end
               end
            end
         end
         ACT_DETECT: begin
            if (detect_enable_ff && !state_in.moving) begin
               state_in = f_go_open(state_in, ctx);
            end
         end
         ACT_BEAM: begin
            if (state_in.moving && !state_in.dir_open) begin
               state_in = f_halt(state_in, ctx);
               cause    = CAUSE_BEAM;
            end
         end
         ACT_OPEN_LIMIT: begin
            if (state_in.moving && state_in.dir_open) begin
               state_in          = f_halt(state_in, ctx);
               state_in.opened   = 1'b1;
               state_in.dir_open = 1'b0;
               cause             = CAUSE_OPEN_LIMIT;
            end
         end
         ACT_CLOSE_LIMIT: begin
            if (state_in.moving && !state_in.dir_open) begin
               state_in          = f_halt(state_in, ctx);
               state_in.closed   = 1'b1;
               state_in.dir_open = 1'b1;
               cause             = CAUSE_CLOSE_LIMIT;
            end
         end
         ACT_OPEN_TORQUE, ACT_CLOSE_TORQUE: begin
            if (torque_enable_ff) begin
               state_in                   = f_halt(state_in, ctx);
               state_in.dir_open          = !state_in.dir_open;
               state_in.autoclose_blocked = 1'b1;
               cause                      = CAUSE_TORQUE;
            end
         end
         ACT_OPEN:  state_in = f_go_open(state_in, ctx);
         ACT_CLOSE: state_in = f_go_close(state_in, ctx);
         ACT_STOP:  state_in = f_halt(state_in, ctx);
         default:   state_in = state_in;
      endcase

      // safety checks while moving, first hit wins
      run_dir     = state_in.dir_open;
      run_limit   = f_must(state_in, run_dir, max_travel_ff) ?
                    CMP_BITS'(max_travel_ff) : CMP_BITS'(state_in.learned_time[run_dir]);
      run_elapsed = CMP_BITS'(TIME_BITS'(tick_in - state_in.run_start[run_dir]));
      if ((cause == CAUSE_NONE) && state_in.moving) begin
         if (!state_in.dir_open && ctx.lvl_beam) begin
            state_in = f_halt(state_in, ctx);
            cause    = CAUSE_BEAM;
         end else if (state_in.dir_open && ctx.lvl_olim) begin
            state_in          = f_halt(state_in, ctx);
            state_in.opened   = 1'b1;
            state_in.dir_open = 1'b0;
            cause             = CAUSE_OPEN_LIMIT;
         end else if (!state_in.dir_open && ctx.lvl_clim) begin
            state_in          = f_halt(state_in, ctx);
            state_in.closed   = 1'b1;
            state_in.dir_open = 1'b1;
            cause             = CAUSE_CLOSE_LIMIT;
         end else if (timeout_enable_ff && (run_elapsed >= run_limit)) begin
            state_in = f_halt(state_in, ctx);
            if (!state_in.dir_open) begin
               state_in.dir_open = 1'b1;
               state_in.closed   = 1'b1;
            end else begin
               state_in.dir_open = 1'b0;
               state_in.opened   = 1'b1;
            end
            cause = CAUSE_TIMEOUT;
         end else if (torque_enable_ff &&
                      (item_ff.open_torque_high || item_ff.close_torque_high)) begin
            state_in                   = f_halt(state_in, ctx);
            state_in.dir_open          = !state_in.dir_open;
            state_in.autoclose_blocked = 1'b1;
            cause                      = CAUSE_TORQUE;
         end
      end
   end

   always_comb begin
      result_in.motor_forward = state_in.moving && (state_in.dir_open == reverse_wiring_ff);
      result_in.motor_reverse = state_in.moving && (state_in.dir_open != reverse_wiring_ff);
      result_in.warning_light = state_in.moving;
      result_in.heading_open  = state_in.dir_open;
      result_in.at_open_end   = ctx.lvl_olim || state_in.opened;
      result_in.at_closed_end = ctx.lvl_clim || state_in.closed;
      result_in.stop_cause    = cause;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff       <= 1'b0;
         result_valid_ff     <= 1'b0;
         state_ff            <= GATE_STATE_RESET;
         tick_ff             <= '0;
         autoclose_ticks_ff  <= AUTOCLOSE_TICKS_RESET;
         autoclose_enable_ff <= 1'b1;
         detect_enable_ff    <= 1'b0;
         reverse_wiring_ff   <= 1'b1;
         torque_enable_ff    <= 1'b0;
         max_travel_ff       <= MAX_TRAVEL_RESET;
         timeout_enable_ff   <= 1'b1;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
         if (advance) begin
            state_ff <= state_in;
            tick_ff  <= tick_in;
         end else if (csr_write && (reg_index == REG_AUTOCLOSE_ENABLE)) begin
            state_ff.autoclose_blocked <= 1'b0;
         end
         if (csr_write) begin
            case (reg_index)
               REG_AUTOCLOSE_TICKS:  autoclose_ticks_ff  <= csr_pwdata[CFG_BITS-1:0];
               REG_AUTOCLOSE_ENABLE: autoclose_enable_ff <= csr_pwdata[0];
               REG_DETECT_ENABLE:    detect_enable_ff    <= csr_pwdata[0];
               REG_REVERSE_WIRING:   reverse_wiring_ff   <= csr_pwdata[0];
               REG_TORQUE_ENABLE:    torque_enable_ff    <= csr_pwdata[0];
               REG_MAX_TRAVEL:       max_travel_ff       <= csr_pwdata[CFG_BITS-1:0];
               REG_TIMEOUT_ENABLE:   timeout_enable_ff   <= csr_pwdata[0];
               default:              timeout_enable_ff   <= timeout_enable_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action            <= req.action;
         item_ff.beam_blocked      <= req.beam_blocked;
         item_ff.open_limit_hit    <= req.open_limit_hit;
         item_ff.close_limit_hit   <= req.close_limit_hit;
         item_ff.open_torque_high  <= req.open_torque_high;
         item_ff.close_torque_high <= req.close_torque_high;
         item_ff.button_level      <= req.button_level;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = result_valid_ff;
   assign rsp.motor_forward = result_ff.motor_forward;
   assign rsp.motor_reverse = result_ff.motor_reverse;
   assign rsp.warning_light = result_ff.warning_light;
   assign rsp.heading_open  = result_ff.heading_open;
   assign rsp.at_open_end   = result_ff.at_open_end;
   assign rsp.at_closed_end = result_ff.at_closed_end;
   assign rsp.stop_cause    = result_ff.stop_cause;

`ifndef SYNTH
   a_motor_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.motor_forward && rsp.motor_reverse))
      else $error("both motor outputs driven");

   a_light_tracks_motor: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.warning_light == (rsp.motor_forward || rsp.motor_reverse)))
      else $error("warning light does not match motor drive");

   a_stop_means_still: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.stop_cause != CAUSE_NONE)) |-> !rsp.warning_light)
      else $error("safety stop reported while still moving");

   a_no_conflict_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.stop_cause < CAUSE_CONFLICT))
      else $error("illegal stop cause");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> (item_valid_ff && $stable(item_ff)))
      else $error("pending request lost from input register");
`endif

endmodule

`default_nettype wire
